// File: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Checks are compiled only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/ssnfa_pkg.sv
// Shared types and constants of the swap slot next-fit allocator.
// No dependencies.
`default_nettype none

package ssnfa_pkg;

  // Field widths of the ports.
  localparam int SLOT_W   = 12;
  localparam int SECTOR_W = 15;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  // Size of the slot map and the sectors that back one slot.
  localparam int MAX_SLOTS        = 4096;
  localparam int SECTORS_PER_SLOT = 8;

  // Slot count after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_SLOTS);

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN_ISSUE,
    S_SCAN,
    S_FREE_CHK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/ssnfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ssnfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/swap_slot_next_fit_allocator.sv
// Next-fit swap slot allocator: top level with the sequencer and used-map datapath.
// Depends on ssnfa_pkg, ssnfa_ram and assert_macros.svh.
//
// Usage:
//   Requests arrive on in_valid/in_ready with op (allocate or free) and slot_index.
//   Each request yields one result on out_valid/out_ready: slot_out, sector_base
//   (slot_out times eight) and status (ok, no free slot, freed slot not allocated).
//   cfg_we/cfg_wdata writes the slot count; write it only while the block is idle.
// Sequencing:
//   One request is in work at a time. A free passes a check state and the response
//   state before its result turns valid; an allocate reads the used-map one 64-bit
//   word per cycle, 1 to 65 words in all. A lowered count below the pointer adds a
//   bit-serial remainder step before the scan. The next request can be taken in the
//   cycle in which the result turns valid.
// Reset:
//   The map reads as all free at once through per-word valid flags, the pointer
//   is zero and the slot count is 4096. No clearing pass is needed.
// Stalls:
//   A result waits in the output register; the next request is still taken
//   and its result is held back until the register is free.
`default_nettype none
`include "assert_macros.svh"

module swap_slot_next_fit_allocator #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write.
  input  wire logic                            cfg_we,
  input  wire logic [ssnfa_pkg::COUNT_W-1:0]   cfg_wdata,
  // Request channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            op,
  input  wire logic [ssnfa_pkg::SLOT_W-1:0]    slot_index,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [ssnfa_pkg::SLOT_W-1:0]    slot_out,
  output logic      [ssnfa_pkg::SECTOR_W-1:0]  sector_base,
  output logic      [ssnfa_pkg::STATUS_W-1:0]  status
);

  import ssnfa_pkg::*;

  localparam int WORD_AW = $clog2(WORD_BITS);
  localparam int ROWS    = MAX_SLOTS / WORD_BITS;
  localparam int ROW_AW  = SLOT_W - WORD_AW;
  localparam int CNT_AW  = $clog2(COUNT_W);
  localparam int LIM_W   = WORD_AW + 1;

  localparam logic [WORD_BITS-1:0] ONES     = {WORD_BITS{1'b1}};
  localparam logic [LIM_W-1:0]     LIM_FULL = LIM_W'(WORD_BITS);

  state_t state, state_next;

  logic [COUNT_W-1:0] slot_count;
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] n_q;
  logic [SLOT_W-1:0]  last_slot;
  logic [SLOT_W-1:0]  start;
  logic [COUNT_W-1:0] mod_num;
  logic [COUNT_W-1:0] mod_rem;
  logic [CNT_AW-1:0]  mod_cnt;
  logic [ROW_AW-1:0]  word_ptr;
  logic               phase_b;
  logic [SLOT_W-1:0]  req_slot;
  logic [SLOT_W-1:0]  res_slot;
  status_t            res_status;
  logic               res_alloc;

  logic [ROWS-1:0]      row_vld;
  logic                 rd_vld_q;
  logic [WORD_BITS-1:0] ram_q;
  logic [WORD_BITS-1:0] rd_word;

  logic                 ram_we;
  logic [ROW_AW-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ROW_AW-1:0]    ram_raddr;

  logic                 in_xfer;
  logic                 out_free;
  logic [COUNT_W-1:0]   last_p1;
  logic                 last_fits;
  logic [COUNT_W:0]     mod_shift;
  logic [COUNT_W:0]     mod_diff;
  logic [COUNT_W-1:0]   mod_rem_next;
  logic [COUNT_W-1:0]   n_m1;
  logic [ROW_AW-1:0]    last_w;
  logic [ROW_AW-1:0]    start_w;
  logic [LIM_W-1:0]     lim_a;
  logic [LIM_W-1:0]     lim;
  logic                 at_start;
  logic                 at_last;
  logic [WORD_BITS-1:0] mask_lo;
  logic [WORD_BITS-1:0] mask_hi;
  logic [WORD_BITS-1:0] free_vec;
  logic                 found;
  logic [WORD_AW-1:0]   found_bit;
  logic                 scan_end;
  logic                 to_phase_b;
  logic [ROW_AW-1:0]    next_ptr;
  logic                 free_hit;

  // Used-map storage, one word of slots per row.
  ssnfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // A row never written since reset reads as all free.
  assign rd_word = rd_vld_q ? ram_q : '0;

  // Slot count clamped to the map size, zero acting as one.
  always_comb begin
    if (slot_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (slot_count > COUNT_W'(MAX_SLOTS)) begin
      n_eff = COUNT_W'(MAX_SLOTS);
    end else begin
      n_eff = slot_count;
    end
  end

  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign last_p1   = COUNT_W'({1'b0, last_slot}) + COUNT_W'(1);
  assign last_fits = COUNT_W'({1'b0, last_slot}) < n_eff;

  // One restoring step of (last_slot + 1) mod count.
  assign mod_shift    = {mod_rem, mod_num[mod_cnt]};
  assign mod_diff     = mod_shift - {1'b0, n_q};
  assign mod_rem_next = (mod_shift >= {1'b0, n_q}) ? mod_diff[COUNT_W-1:0]
                                                   : mod_shift[COUNT_W-1:0];

  // Word range bounds of the scan.
  assign n_m1    = n_q - COUNT_W'(1);
  assign last_w  = n_m1[SLOT_W-1:WORD_AW];
  assign start_w = start[SLOT_W-1:WORD_AW];
  assign lim_a   = LIM_W'({1'b0, n_m1[WORD_AW-1:0]}) + LIM_W'(1);
  assign at_start = word_ptr == start_w;
  assign at_last  = word_ptr == last_w;

  // Candidate mask: the first pass covers start up to count-1, the second
  // pass covers zero up to the slot before start.
  always_comb begin
    if (!phase_b && at_start) begin
      mask_lo = ONES << start[WORD_AW-1:0];
    end else begin
      mask_lo = ONES;
    end
    if (phase_b) begin
      lim = at_start ? LIM_W'({1'b0, start[WORD_AW-1:0]}) : LIM_FULL;
    end else begin
      lim = at_last ? lim_a : LIM_FULL;
    end
    mask_hi = ~(ONES << lim);
  end

  assign free_vec = ~rd_word & mask_lo & mask_hi;
  assign found    = |free_vec;

  // Lowest free candidate in the word.
  always_comb begin
    found_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found_bit = WORD_AW'(i);
      end
    end
  end

  assign scan_end   = phase_b && at_start;
  assign to_phase_b = !phase_b && at_last;
  assign next_ptr   = to_phase_b ? '0 : word_ptr + ROW_AW'(1);
  assign free_hit   = rd_word[req_slot[WORD_AW-1:0]];

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (op == OP_FREE) begin
            state_next = S_FREE_CHK;
          end else if (last_fits) begin
            state_next = S_SCAN_ISSUE;
          end else begin
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_cnt == '0) begin
          state_next = S_SCAN_ISSUE;
        end
      end
      S_SCAN_ISSUE: state_next = S_SCAN;
      S_SCAN: begin
        if (found || scan_end) begin
          state_next = S_RESP;
        end
      end
      S_FREE_CHK: state_next = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and RAM port control.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = word_ptr;
    ram_wdata = rd_word;
    ram_raddr = word_ptr;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = slot_index[SLOT_W-1:WORD_AW];
      end
      S_SCAN_ISSUE: ram_raddr = start_w;
      S_SCAN: begin
        ram_raddr = next_ptr;
        ram_we    = found;
        ram_wdata = rd_word | (WORD_BITS'(1) << found_bit);
      end
      S_FREE_CHK: begin
        ram_waddr = req_slot[SLOT_W-1:WORD_AW];
        ram_we    = free_hit;
        ram_wdata = rd_word & ~(WORD_BITS'(1) << req_slot[WORD_AW-1:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= COUNT_RESET;
    end else if (cfg_we) begin
      slot_count <= cfg_wdata;
    end
  end

  // Row valid flags and the flag of the row being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= row_vld[ram_raddr];
      if (ram_we) begin
        row_vld[ram_waddr] <= 1'b1;
      end
    end
  end

  // Next-fit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_slot <= '0;
    end else if (state == S_SCAN && found) begin
      last_slot <= {word_ptr, found_bit};
    end
  end

  // Request datapath: start point, remainder unit, scan pointer and result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n_q       <= n_eff;
        req_slot  <= slot_index;
        res_alloc <= op == OP_ALLOC;
        mod_num   <= last_p1;
        mod_rem   <= '0;
        mod_cnt   <= CNT_AW'(COUNT_W - 1);
        if (last_p1 == n_eff) begin
          start <= '0;
        end else begin
          start <= last_p1[SLOT_W-1:0];
        end
      end
      S_MOD: begin
        mod_rem <= mod_rem_next;
        mod_cnt <= mod_cnt - CNT_AW'(1);
        if (mod_cnt == '0) begin
          start <= mod_rem_next[SLOT_W-1:0];
        end
      end
      S_SCAN_ISSUE: begin
        word_ptr <= start_w;
        phase_b  <= 1'b0;
      end
      S_SCAN: begin
        if (found) begin
          res_slot   <= {word_ptr, found_bit};
          res_status <= ST_OK;
        end else if (scan_end) begin
          res_slot   <= '0;
          res_status <= ST_FULL;
        end else begin
          word_ptr <= next_ptr;
          phase_b  <= phase_b || to_phase_b;
        end
      end
      S_FREE_CHK: begin
        res_slot   <= req_slot;
        res_status <= free_hit ? ST_OK : ST_NOT_USED;
      end
      default: begin
        res_alloc <= res_alloc;
      end
    endcase
  end

  // Output register; holds the result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      slot_out    <= res_slot;
      sector_base <= SECTOR_W'(32'(res_slot) * SECTORS_PER_SLOT);
      status      <= res_status;
    end
  end

  // Map writes happen only in the two read-modify-write states.
  `ASSERT_IMPL(a_we_state, clk, rst, ram_we, (state == S_SCAN || state == S_FREE_CHK))
  // The scan start lies inside the configured slot range.
  `ASSERT_IMPL(a_start_range, clk, rst, (state == S_SCAN), (COUNT_W'({1'b0, start}) < n_q))
  // An allocated slot lies inside the configured slot range.
  `ASSERT_IMPL(a_alloc_range, clk, rst,
               (state == S_RESP && res_alloc && res_status == ST_OK),
               (COUNT_W'({1'b0, res_slot}) < n_q))
  // A new result is only loaded from the response state.
  `ASSERT_IMPL(a_load_src, clk, rst, $rose(out_valid), ($past(state) == S_RESP))

endmodule

`default_nettype wire
